@@ rtl/core/tm_pkg.sv @@
`timescale 1ns / 1ps
// shared constants for the two-body transverse mass unit
// no dependencies; imported by the interfaces and every module of the block

package tm_pkg;

  // default field widths of the momentum words
  localparam int MOMENTUM_WIDTH_DEF      = 16;
  // extra fraction bits carried through the transverse energies
  localparam int EXTRA_FRACTION_BITS_DEF = 8;

endpackage

@@ rtl/core/tm_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels of the transverse mass unit: object pair in, mass out
// depends on tm_pkg for the default momentum width

interface tm_pair_if import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH = MOMENTUM_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [MOMENTUM_WIDTH-1:0] px_a;
  logic signed [MOMENTUM_WIDTH-1:0] py_a;
  logic        [MOMENTUM_WIDTH-2:0] mass_a;
  logic signed [MOMENTUM_WIDTH-1:0] px_b;
  logic signed [MOMENTUM_WIDTH-1:0] py_b;
  logic        [MOMENTUM_WIDTH-2:0] mass_b;

  modport source (output valid, px_a, py_a, mass_a, px_b, py_b, mass_b, input ready);
  modport sink   (input valid, px_a, py_a, mass_a, px_b, py_b, mass_b, output ready);
endinterface

interface tm_result_if import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH = MOMENTUM_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [MOMENTUM_WIDTH:0]   transverse_mass;

  modport source (output valid, transverse_mass, input ready);
  modport sink   (input valid, transverse_mass, output ready);
endinterface

@@ rtl/core/tm_front.sv @@
`timescale 1ns / 1ps
// input stages: pair sums, squares of every component, squared-sum totals
// depends on tm_pkg and tm_pair_if; three register stages

module tm_front import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH = MOMENTUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  tm_pair_if.sink                       pair,
  output logic                          out_valid,
  output logic [2*MOMENTUM_WIDTH-1:0]   sum_a,
  output logic [2*MOMENTUM_WIDTH-1:0]   sum_b,
  output logic [2*MOMENTUM_WIDTH+1:0]   need
);

  localparam int MW  = MOMENTUM_WIDTH;
  localparam int SQW = 2*MW;
  localparam int NW  = 2*MW+2;

  logic [2:0] vld;

  // stage 1: captured word and component sums
  logic signed [MW-1:0] pxa, pya, pxb, pyb;
  logic        [MW-2:0] ma, mb;
  logic signed [MW:0]   sx, sy;

  // stage 2: squares
  logic [2*MW-2:0] sq_pxa, sq_pya, sq_pxb, sq_pyb;
  logic [2*MW-3:0] sq_ma, sq_mb;
  logic [2*MW:0]   sq_sx, sq_sy;

  logic signed [2*MW-1:0] pxa_full, pya_full, pxb_full, pyb_full;
  logic signed [2*MW+1:0] sx_full, sy_full;

  assign pair.ready = en;

  assign pxa_full = pxa * pxa;
  assign pya_full = pya * pya;
  assign pxb_full = pxb * pxb;
  assign pyb_full = pyb * pyb;
  assign sx_full  = sx * sx;
  assign sy_full  = sy * sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], pair.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxa    <= pair.px_a;
      pya    <= pair.py_a;
      pxb    <= pair.px_b;
      pyb    <= pair.py_b;
      ma     <= pair.mass_a;
      mb     <= pair.mass_b;
      sx     <= (MW+1)'(pair.px_a) + (MW+1)'(pair.px_b);
      sy     <= (MW+1)'(pair.py_a) + (MW+1)'(pair.py_b);

      sq_pxa <= pxa_full[2*MW-2:0];
      sq_pya <= pya_full[2*MW-2:0];
      sq_pxb <= pxb_full[2*MW-2:0];
      sq_pyb <= pyb_full[2*MW-2:0];
      sq_ma  <= ma * ma;
      sq_mb  <= mb * mb;
      sq_sx  <= sx_full[2*MW:0];
      sq_sy  <= sy_full[2*MW:0];

      sum_a  <= SQW'(sq_pxa) + SQW'(sq_pya) + SQW'(sq_ma);
      sum_b  <= SQW'(sq_pxb) + SQW'(sq_pyb) + SQW'(sq_mb);
      need   <= NW'(sq_sx) + NW'(sq_sy);
    end
  end

  assign out_valid = vld[2];

endmodule

@@ rtl/core/tm_isqrt.sv @@
`timescale 1ns / 1ps
// pipelined floor square root, one root bit resolved per register stage
// depends on tm_pkg; lanes share the valid chain and the stall

module tm_isqrt import tm_pkg::*; #(
  parameter int QW    = MOMENTUM_WIDTH_DEF + EXTRA_FRACTION_BITS_DEF,
  parameter int LANES = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][2*QW-1:0]   radicand,
  output logic                         out_valid,
  output logic [LANES-1:0][QW-1:0]     root
);

  localparam int WIDE = 2*QW;

  logic [WIDE-1:0] src_rem  [QW][LANES];
  logic [QW-1:0]   src_root [QW][LANES];
  logic [WIDE-1:0] rem_next [QW][LANES];
  logic [QW-1:0]   root_next[QW][LANES];
  logic [WIDE-1:0] rem      [QW][LANES];
  logic [QW-1:0]   root_acc [QW][LANES];
  logic [QW-1:0]   vld;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      src_rem[0][l]  = radicand[l];
      src_root[0][l] = '0;
    end
    for (int s = 1; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        src_rem[s][l]  = rem[s-1][l];
        src_root[s][l] = root_acc[s-1][l];
      end
    end
  end

  // remainder holds radicand minus root squared; trial is the growth of the
  // square when the next bit is set
  always_comb begin
    logic [WIDE-1:0] trial;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = (WIDE'(src_root[s][l]) << (QW - s)) | (WIDE'(1) << (2*(QW-1-s)));
        if (src_rem[s][l] >= trial) begin
          rem_next[s][l]  = src_rem[s][l] - trial;
          root_next[s][l] = src_root[s][l] | (QW'(1) << (QW-1-s));
        end else begin
          rem_next[s][l]  = src_rem[s][l];
          root_next[s][l] = src_root[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem      <= rem_next;
      root_acc <= root_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = root_acc[QW-1][l];
    end
  end

  assign out_valid = vld[QW-1];

endmodule

@@ rtl/core/tm_delay.sv @@
`timescale 1ns / 1ps
// stall-aware delay line that keeps a value level with a pipelined unit
// depends on tm_pkg for the default width and depth

module tm_delay import tm_pkg::*; #(
  parameter int WIDTH = 2*MOMENTUM_WIDTH_DEF + 2,
  parameter int DEPTH = MOMENTUM_WIDTH_DEF + EXTRA_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

@@ rtl/core/tm_combine.sv @@
`timescale 1ns / 1ps
// energy sum squared in split partial products, minus summed momenta squared
// depends on tm_pkg; four register stages, negative difference clamps to zero

module tm_combine import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH      = MOMENTUM_WIDTH_DEF,
  parameter int EXTRA_FRACTION_BITS = EXTRA_FRACTION_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [MOMENTUM_WIDTH+EXTRA_FRACTION_BITS-1:0] ea,
  input  logic [MOMENTUM_WIDTH+EXTRA_FRACTION_BITS-1:0] eb,
  input  logic [2*MOMENTUM_WIDTH+1:0]                   need,
  output logic                                          out_valid,
  output logic [2*MOMENTUM_WIDTH+1:0]                   dsq
);

  localparam int MW  = MOMENTUM_WIDTH;
  localparam int F   = EXTRA_FRACTION_BITS;
  localparam int QE  = MW + F;
  localparam int SW  = QE + 1;
  localparam int H   = (SW + 1) / 2;
  localparam int HIW = SW - H;
  localparam int HW  = 2*SW;
  localparam int NW  = 2*MW + 2;
  localparam int DW  = 2*MW + 2;

  logic [3:0]       vld;
  logic [SW-1:0]    esum;
  logic [H-1:0]     lo;
  logic [HIW-1:0]   hi;
  logic [2*H-1:0]   p_lo;
  logic [SW-1:0]    p_mid;
  logic [2*HIW-1:0] p_hi;
  logic [HW-1:0]    have;
  logic [NW-1:0]    need1, need2, need3;
  logic [HW:0]      diff;

  assign lo   = esum[H-1:0];
  assign hi   = esum[SW-1:H];
  assign diff = {1'b0, have} - ((HW+1)'(need3) << (2*F));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esum  <= SW'(ea) + SW'(eb);
      need1 <= need;

      p_lo  <= lo * lo;
      p_mid <= hi * lo;
      p_hi  <= hi * hi;
      need2 <= need1;

      // the cross term appears twice, hence the extra bit of shift
      have  <= (HW'(p_hi) << (2*H)) + (HW'(p_mid) << (H+1)) + HW'(p_lo);
      need3 <= need2;

      // drop the squared fraction bits: floor root of the floor is exact
      dsq   <= diff[HW] ? '0 : DW'(diff[HW-1:0] >> (2*F));
    end
  end

  assign out_valid = vld[3];

endmodule

@@ rtl/core/tm_out_buf.sv @@
`timescale 1ns / 1ps
// two-word output buffer that decouples the result channel from the pipeline
// depends on tm_pkg and tm_result_if

module tm_out_buf import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH = MOMENTUM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [MOMENTUM_WIDTH:0] in_data,
  output logic                    space,
  tm_result_if.source             result
);

  logic [MOMENTUM_WIDTH:0] slot [2];
  logic [1:0]              count;
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic                    push;
  logic                    pop;

  // space comes from registered state only, so ready never depends on result.ready
  assign space = (count != 2'd2);
  assign push  = in_valid & space;
  assign pop   = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  assign result.valid           = (count != 2'd0);
  assign result.transverse_mass = slot[rd_ptr];

endmodule

@@ rtl/core/two_body_transverse_mass_unit.sv @@
`timescale 1ns / 1ps
// top level of the two-body transverse mass unit
// depends on tm_pkg, tm_if, tm_front, tm_isqrt, tm_delay, tm_combine, tm_out_buf

// Takes one object pair per clock and returns its transverse mass, one word per pair,
// in order. A pair passes through tm_front, the two-lane energy square root, tm_combine,
// the final square root and the output buffer; both pipelined square roots resolve one
// root bit per stage. A two-word buffer holds finished results; pair.ready falls only
// while both buffer words are occupied, and the whole pipeline then holds until a result
// is taken.

module two_body_transverse_mass_unit import tm_pkg::*; #(
  parameter int MOMENTUM_WIDTH      = MOMENTUM_WIDTH_DEF,
  parameter int EXTRA_FRACTION_BITS = EXTRA_FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tm_pair_if.sink     pair,
  tm_result_if.source result
);

  localparam int MW  = MOMENTUM_WIDTH;
  localparam int F   = EXTRA_FRACTION_BITS;
  localparam int QE  = MW + F;
  localparam int EW  = 2*QE;
  localparam int SQW = 2*MW;
  localparam int NW  = 2*MW + 2;
  localparam int QF  = MW + 1;

  logic                   en;
  logic                   front_valid;
  logic [SQW-1:0]         sum_a, sum_b;
  logic [NW-1:0]          need, need_dly;
  logic [1:0][EW-1:0]     e_rad;
  logic                   e_valid;
  logic [1:0][QE-1:0]     e_root;
  logic                   comb_valid;
  logic [2*QF-1:0]        dsq;
  logic [0:0][2*QF-1:0]   f_rad;
  logic                   f_valid;
  logic [0:0][QF-1:0]     f_root;

  tm_front #(.MOMENTUM_WIDTH(MW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .pair      (pair),
    .out_valid (front_valid),
    .sum_a     (sum_a),
    .sum_b     (sum_b),
    .need      (need)
  );

  // energies carry the extra fraction bits: radicand scaled by their square
  assign e_rad[0] = EW'(sum_a) << (2*F);
  assign e_rad[1] = EW'(sum_b) << (2*F);

  tm_isqrt #(.QW(QE), .LANES(2)) u_energy (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .radicand  (e_rad),
    .out_valid (e_valid),
    .root      (e_root)
  );

  tm_delay #(.WIDTH(NW), .DEPTH(QE)) u_need_dly (
    .clk  (clk),
    .en   (en),
    .din  (need),
    .dout (need_dly)
  );

  tm_combine #(.MOMENTUM_WIDTH(MW), .EXTRA_FRACTION_BITS(F)) u_combine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .ea        (e_root[0]),
    .eb        (e_root[1]),
    .need      (need_dly),
    .out_valid (comb_valid),
    .dsq       (dsq)
  );

  assign f_rad[0] = dsq;

  tm_isqrt #(.QW(QF), .LANES(1)) u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (comb_valid),
    .radicand  (f_rad),
    .out_valid (f_valid),
    .root      (f_root)
  );

  tm_out_buf #(.MOMENTUM_WIDTH(MW)) u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_data  (f_root[0]),
    .space    (en),
    .result   (result)
  );

endmodule
